// File: rtl/core/rora_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rora_pkg
// Types and constants shared by the range outlier-rejecting average core.
// ----------------------------------------------------------------------------
package rora_pkg;

    localparam int unsigned DIST_W     = 16;
    localparam int unsigned ID_W       = 8;
    localparam int unsigned ATTEMPTS   = 5;
    localparam int unsigned AVG_SLOTS  = 4;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGED_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_THRESHOLD = 1'd1;

    localparam logic [DIST_W-1:0] FAIL_VALUE      = 16'hFFFF;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd30;

    // Reciprocal of three, exact for any dividend below 2^DIV3_SHIFT.
    localparam int unsigned       DIV3_SHIFT = 19;
    localparam logic [SUM_W-1:0]  DIV3_MUL   = 18'd174763;
    localparam int unsigned       PROD_W     = 2 * SUM_W;

    typedef struct packed {
        logic [ID_W-1:0]      target_id;
        logic [ATTEMPTS-1:0]  valid_mask;
        logic [DIST_W-1:0]    dist_a0;
        logic [DIST_W-1:0]    dist_a1;
        logic [DIST_W-1:0]    dist_a2;
        logic [DIST_W-1:0]    dist_a3;
        logic [DIST_W-1:0]    dist_a4;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [DIST_W-1:0] range_cm;
        logic              failed;
    } t_out;

endpackage

// File: rtl/core/range_outlier_reject_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_outlier_reject_average_core
// Seven-stage pipeline that turns one ranging request into one filtered
// distance: first successful attempt, or an outlier-rejecting mean.
// ----------------------------------------------------------------------------
// A request is registered through each stage in turn, and its result is presented
// from the output register once it reaches the last stage.
// Throughput is one request per cycle; the whole pipeline holds when the
// output register is full and not taken.
// Synchronous active-low reset empties the pipeline, selects single mode
// and sets the outlier threshold to 30 cm.
module range_outlier_reject_average_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  rora_pkg::t_in                          i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output rora_pkg::t_out                         o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [rora_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rora_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import rora_pkg::*;

    localparam int unsigned STAGES = 7;

    typedef struct packed {
        logic [ID_W-1:0]                   id;
        logic                              avg;
        logic [DIST_W-1:0]                 thr;
        logic [DIST_W-1:0]                 single_range;
        logic                              single_fail;
        logic [AVG_SLOTS-1:0][DIST_W-1:0]  samp;
        logic [2:0]                        n;
        logic [DIST_W-1:0]                 last;
        logic [2:0]                        acc;
        logic [SUM_W-1:0]                  sum;
        logic [1:0]                        cnt;
        logic [PROD_W-1:0]                 prod;
        logic [DIST_W-1:0]                 mean;
        logic                              refine;
        logic [SUM_W-1:0]                  sum2;
        logic [2:0]                        cnt2;
        logic [DIST_W-1:0]                 res_range;
        logic                              res_fail;
    } t_work;

    logic              r_avg_mode;
    logic [DIST_W-1:0] r_threshold;
    logic [STAGES:1]   r_v;
    t_work             r_w [STAGES:1];
    t_work             n_w [STAGES:1];
    logic              en;

    assign en          = !r_v[STAGES] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_v[STAGES];
    assign o_out_data  = '{result_id: r_w[STAGES].id,
                           range_cm:  r_w[STAGES].res_range,
                           failed:    r_w[STAGES].res_fail};

    // Stage 1: snapshot configuration, pick the first success and compact samples.
    always_comb begin
        logic [DIST_W-1:0] d [ATTEMPTS];
        logic [2:0]        pos;
        logic [2:0]        nm1;
        logic              found;
        n_w[1]       = '0;
        d[0]         = i_in_data.dist_a0;
        d[1]         = i_in_data.dist_a1;
        d[2]         = i_in_data.dist_a2;
        d[3]         = i_in_data.dist_a3;
        d[4]         = i_in_data.dist_a4;
        n_w[1].id    = i_in_data.target_id;
        n_w[1].avg   = r_avg_mode;
        n_w[1].thr   = r_threshold;
        found        = 1'b0;
        n_w[1].single_range = FAIL_VALUE;
        n_w[1].single_fail  = 1'b1;
        for (int k = 0; k < ATTEMPTS; k++) begin
            if (i_in_data.valid_mask[k] && !found) begin
                found               = 1'b1;
                n_w[1].single_range = d[k];
                n_w[1].single_fail  = 1'b0;
            end
        end
        pos = 3'd0;
        for (int k = 0; k < AVG_SLOTS; k++) begin
            if (i_in_data.valid_mask[k]) begin
                n_w[1].samp[pos[1:0]] = d[k];
                pos = pos + 3'd1;
            end
        end
        n_w[1].n    = pos;
        nm1         = pos - 3'd1;
        n_w[1].last = (pos != 3'd0) ? n_w[1].samp[nm1[1:0]] : '0;
    end

    // Stage 2: one-sided pair test, earlier minus later below the threshold.
    always_comb begin
        logic signed [DIST_W:0] diff;
        n_w[2]     = r_w[1];
        n_w[2].acc = '0;
        for (int k = 0; k < AVG_SLOTS - 1; k++) begin
            diff = $signed({1'b0, r_w[1].samp[k]}) - $signed({1'b0, r_w[1].samp[k+1]});
            n_w[2].acc[k] = ((3'(k) + 3'd1) < r_w[1].n) &&
                            (diff < $signed({1'b0, r_w[1].thr}));
        end
    end

    // Stage 3: sum and count of the accepted samples.
    always_comb begin
        n_w[3]     = r_w[2];
        n_w[3].sum = '0;
        n_w[3].cnt = '0;
        for (int k = 0; k < AVG_SLOTS - 1; k++) begin
            if (r_w[2].acc[k]) begin
                n_w[3].sum = n_w[3].sum + SUM_W'(r_w[2].samp[k]);
                n_w[3].cnt = n_w[3].cnt + 2'd1;
            end
        end
    end

    // Stage 4: reciprocal product for a division by three.
    always_comb begin
        n_w[4]      = r_w[3];
        n_w[4].prod = r_w[3].sum * DIV3_MUL;
    end

    // Stage 5: mean, and whether the last sample refines it.
    always_comb begin
        logic signed [DIST_W:0] diff;
        logic        [DIST_W:0] adiff;
        n_w[5] = r_w[4];
        unique case (r_w[4].cnt)
            2'd2:    n_w[5].mean = r_w[4].sum[DIST_W:1];
            2'd3:    n_w[5].mean = r_w[4].prod[DIV3_SHIFT +: DIST_W];
            default: n_w[5].mean = r_w[4].sum[DIST_W-1:0];
        endcase
        diff  = $signed({1'b0, r_w[4].last}) - $signed({1'b0, n_w[5].mean});
        adiff = (diff < 0) ? 17'(-diff) : 17'(diff);
        n_w[5].refine = adiff < {1'b0, r_w[4].thr};
        n_w[5].sum2   = r_w[4].sum + SUM_W'(r_w[4].last);
        n_w[5].cnt2   = {1'b0, r_w[4].cnt} + 3'd1;
    end

    // Stage 6: reciprocal product for the refined mean.
    always_comb begin
        n_w[6]      = r_w[5];
        n_w[6].prod = r_w[5].sum2 * DIV3_MUL;
    end

    // Stage 7: result selection into the output register.
    always_comb begin
        logic [DIST_W-1:0] refined;
        n_w[7] = r_w[6];
        unique case (r_w[6].cnt2)
            3'd2:    refined = r_w[6].sum2[DIST_W:1];
            3'd3:    refined = r_w[6].prod[DIV3_SHIFT +: DIST_W];
            default: refined = r_w[6].sum2[DIST_W+1:2];
        endcase
        priority if (!r_w[6].avg) begin
            n_w[7].res_range = r_w[6].single_range;
            n_w[7].res_fail  = r_w[6].single_fail;
        end else if (r_w[6].cnt == 2'd0) begin
            n_w[7].res_range = FAIL_VALUE;
            n_w[7].res_fail  = 1'b1;
        end else begin
            n_w[7].res_range = r_w[6].refine ? refined : r_w[6].mean;
            n_w[7].res_fail  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_mode  <= 1'b0;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AVERAGED_MODE:     r_avg_mode  <= i_cfg_data[0];
                CFG_OUTLIER_THRESHOLD: r_threshold <= i_cfg_data;
                default:               r_threshold <= r_threshold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[STAGES-1:1], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 1; s <= STAGES; s++) begin
                r_w[s] <= n_w[s];
            end
        end
    end

endmodule
